FILE: src/dmbm_pkg.sv
`default_nettype none

package dmbm_pkg;

   // sample width, Q1.(DW-1)
   localparam int DW   = 16;
   localparam int FRAC = DW - 1;

   // wide working width for products, sums and rounding
   localparam int AW = 2 * DW + 4;

   localparam int SHIFT_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = SHIFT_W;

   // request commands
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FFT_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONJ_TW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS    = 2'd3;

   localparam logic signed [AW-1:0] SAT_MAX = AW'((64'sd1 <<< (DW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);

   // clamp a wide signed value to the sample range
   function automatic logic signed [DW-1:0] sat_dw(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] c;
      begin
         c = v;
         if (v > SAT_MAX) begin
            c = SAT_MAX;
         end else if (v < SAT_MIN) begin
            c = SAT_MIN;
         end
         sat_dw = c[DW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/dual_mode_butterfly_mac_pe.sv
// Dual-mode systolic processing element. Each request is either a load
// (cmd=1), which stores a complex twiddle when fft_mode=1 or a real weight
// when fft_mode=0 and gives no response, or a data request. In FFT mode a
// data request with both operands, once a twiddle is loaded, gives
// Y0 = (X0+X1)>>s and Y1 = ((X0-X1)*W)>>s with X0 on mac_*, X1 on x_*,
// s = scale_shift and W optionally conjugated; in GEMM mode, once a weight
// is loaded, it gives mac + x*w (a missing operand counts as zero) and
// forwards x; with bypass set the inputs are copied to the outputs.
// All values are Q1.15, rounded half up and saturated. Requests that yield
// nothing are dropped silently. Pipeline: a request is captured in an input
// register, worked out by one pass of logic (four 17x17 multipliers and
// two sums for the butterfly) and lands in the response register, which
// drives rsp_valid; one request per cycle is sustained, but a stalled
// response holds the pipe and req_ready then follows rsp_ready. Configuration
// must only be written while the element is empty.
`default_nettype none

module dual_mode_butterfly_mac_pe
   import dmbm_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_cmd,
   input  wire  signed [DW-1:0]         req_weight_re,
   input  wire  signed [DW-1:0]         req_weight_im,
   input  wire  signed [DW-1:0]         req_x_re,
   input  wire  signed [DW-1:0]         req_x_im,
   input  wire                          req_x_valid,
   input  wire  signed [DW-1:0]         req_mac_re,
   input  wire  signed [DW-1:0]         req_mac_im,
   input  wire                          req_mac_present,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [DW-1:0]         rsp_mac_out_re,
   output logic signed [DW-1:0]         rsp_mac_out_im,
   output logic signed [DW-1:0]         rsp_x_out_re,
   output logic signed [DW-1:0]         rsp_x_out_im,
   output logic                         rsp_mac_out_valid,
   output logic                         rsp_x_out_valid,
   // configuration writes
   input  wire                          csr_we,
   input  wire  [CSR_IDX_W-1:0]         csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_wdata
);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic               fft_mode_ff;
   logic               conj_tw_ff;
   logic [SHIFT_W-1:0] scale_sh_ff;
   logic               bypass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fft_mode_ff <= 1'b0;
         conj_tw_ff  <= 1'b0;
         scale_sh_ff <= '0;
         bypass_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FFT_MODE: fft_mode_ff <= csr_wdata[0];
            CSR_CONJ_TW:  conj_tw_ff  <= csr_wdata[0];
            CSR_SCALE_SH: scale_sh_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_BYPASS:   bypass_ff   <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // pipeline control
   // input register (s1) feeds the response register (s2); s1 moves on
   // whenever s2 is free or being emptied this cycle
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s2_free;
   logic s1_fire;
   logic req_fire;

   assign s2_free   = !s2_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_fire  = req_valid && req_ready;

   // input register payload
   logic                 s1_cmd_ff;
   logic signed [DW-1:0] s1_w_re_ff, s1_w_im_ff;
   logic signed [DW-1:0] s1_x_re_ff, s1_x_im_ff;
   logic signed [DW-1:0] s1_m_re_ff, s1_m_im_ff;
   logic                 s1_xv_ff, s1_mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_cmd;
         s1_w_re_ff <= req_weight_re;
         s1_w_im_ff <= req_weight_im;
         s1_x_re_ff <= req_x_re;
         s1_x_im_ff <= req_x_im;
         s1_xv_ff   <= req_x_valid;
         s1_m_re_ff <= req_mac_re;
         s1_m_im_ff <= req_mac_im;
         s1_mv_ff   <= req_mac_present;
      end
   end

   // ---------------------------------------------------------------------
   // coefficient state, updated as a load leaves the input register so that
   // the request right behind it already sees the new value
   // ---------------------------------------------------------------------
   logic signed [DW-1:0] tw_re_ff, tw_im_ff, gemm_w_ff;
   logic                 tw_loaded_ff, w_loaded_ff;
   logic                 load_fire;

   assign load_fire = s1_fire && (s1_cmd_ff == CMD_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_re_ff     <= '0;
         tw_im_ff     <= '0;
         tw_loaded_ff <= 1'b0;
         gemm_w_ff    <= '0;
         w_loaded_ff  <= 1'b0;
      end else if (load_fire) begin
         if (fft_mode_ff) begin
            tw_re_ff     <= s1_w_re_ff;
            tw_im_ff     <= s1_w_im_ff;
            tw_loaded_ff <= 1'b1;
         end else begin
            gemm_w_ff   <= s1_w_re_ff;
            w_loaded_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // butterfly datapath
   // ---------------------------------------------------------------------
   logic signed [DW:0]     sum_re, sum_im;   // X0 + X1
   logic signed [DW:0]     dif_re, dif_im;   // X0 - X1
   logic signed [DW:0]     tw_re_x, tw_im_x; // twiddle, im conjugated exactly if conj_tw set
   logic [AW-1:0]          rnd_y0;
   logic signed [AW-1:0]   y0_re_w, y0_im_w;
   logic signed [2*DW+1:0] p_rr, p_ii, p_ri, p_ir;
   logic [AW-1:0]          rnd_y1;
   logic [5:0]             sh_y1;
   logic signed [AW-1:0]   y1_re_w, y1_im_w;

   assign sum_re = (DW+1)'(s1_m_re_ff) + (DW+1)'(s1_x_re_ff);
   assign sum_im = (DW+1)'(s1_m_im_ff) + (DW+1)'(s1_x_im_ff);
   assign dif_re = (DW+1)'(s1_m_re_ff) - (DW+1)'(s1_x_re_ff);
   assign dif_im = (DW+1)'(s1_m_im_ff) - (DW+1)'(s1_x_im_ff);

   assign tw_re_x = (DW+1)'(tw_re_ff);
   assign tw_im_x = conj_tw_ff ? -((DW+1)'(tw_im_ff)) : (DW+1)'(tw_im_ff);

   // half an lsb of the shifted result, nothing when the shift is zero
   assign rnd_y0  = (AW'(1) << scale_sh_ff) >> 1;
   assign y0_re_w = (AW'(sum_re) + $signed(rnd_y0)) >>> scale_sh_ff;
   assign y0_im_w = (AW'(sum_im) + $signed(rnd_y0)) >>> scale_sh_ff;

   assign p_rr = dif_re * tw_re_x;
   assign p_ii = dif_im * tw_im_x;
   assign p_ri = dif_re * tw_im_x;
   assign p_ir = dif_im * tw_re_x;

   assign sh_y1   = 6'(FRAC) + 6'(scale_sh_ff);
   assign rnd_y1  = (AW'(1) << sh_y1) >> 1;
   assign y1_re_w = (AW'(p_rr) - AW'(p_ii) + $signed(rnd_y1)) >>> sh_y1;
   assign y1_im_w = (AW'(p_ri) + AW'(p_ir) + $signed(rnd_y1)) >>> sh_y1;

   // ---------------------------------------------------------------------
   // multiply-accumulate datapath
   // ---------------------------------------------------------------------
   logic signed [DW-1:0]   g_x, g_m;
   logic signed [2*DW-1:0] g_prod;
   logic signed [AW-1:0]   g_sum;

   assign g_x    = s1_xv_ff ? s1_x_re_ff : '0;
   assign g_m    = s1_mv_ff ? s1_m_re_ff : '0;
   assign g_prod = g_x * gemm_w_ff;
   assign g_sum  = ((AW'(g_prod) + (AW'(1) <<< (FRAC - 1))) >>> FRAC) + AW'(g_m);

   // ---------------------------------------------------------------------
   // result selection
   // ---------------------------------------------------------------------
   logic                 res_en;
   logic signed [DW-1:0] res_m_re, res_m_im, res_x_re, res_x_im;
   logic                 res_mv, res_xv;

   always_comb begin
      res_en   = 1'b0;
      res_m_re = s1_m_re_ff;
      res_m_im = s1_m_im_ff;
      res_x_re = s1_x_re_ff;
      res_x_im = s1_x_im_ff;
      res_mv   = 1'b1;
      res_xv   = 1'b1;
      if (s1_cmd_ff == CMD_LOAD) begin
         res_en = 1'b0;
      end else if (bypass_ff) begin
         // straight copy, valid flags included
         res_en = s1_xv_ff || s1_mv_ff;
         res_mv = s1_mv_ff;
         res_xv = s1_xv_ff;
      end else if (fft_mode_ff) begin
         res_en   = s1_xv_ff && s1_mv_ff && tw_loaded_ff;
         res_m_re = sat_dw(y0_re_w);
         res_m_im = sat_dw(y0_im_w);
         res_x_re = sat_dw(y1_re_w);
         res_x_im = sat_dw(y1_im_w);
      end else begin
         res_en   = w_loaded_ff && (s1_xv_ff || s1_mv_ff);
         res_m_re = sat_dw(g_sum);
         res_m_im = '0;
         res_x_re = g_x;
         res_x_im = '0;
      end
   end

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   logic                 s2_valid_in;
   logic signed [DW-1:0] s2_m_re_ff, s2_m_im_ff, s2_x_re_ff, s2_x_im_ff;
   logic                 s2_mv_ff, s2_xv_ff;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_free) begin
         s2_valid_in = s1_fire && res_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && res_en) begin
         s2_m_re_ff <= res_m_re;
         s2_m_im_ff <= res_m_im;
         s2_x_re_ff <= res_x_re;
         s2_x_im_ff <= res_x_im;
         s2_mv_ff   <= res_mv;
         s2_xv_ff   <= res_xv;
      end
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_mac_out_re    = s2_m_re_ff;
   assign rsp_mac_out_im    = s2_m_im_ff;
   assign rsp_x_out_re      = s2_x_re_ff;
   assign rsp_x_out_im      = s2_x_im_ff;
   assign rsp_mac_out_valid = s2_mv_ff;
   assign rsp_x_out_valid   = s2_xv_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // an empty response register never blocks new requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s2_valid_ff |-> req_ready)
      else $error("request blocked with empty response register");

   // a load request never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_cmd_ff == CMD_LOAD && !rsp_valid) |=> !rsp_valid)
      else $error("load request produced a response");

   // once loaded, a twiddle stays loaded until reset
   a_tw_sticky: assert property (@(posedge clock) disable iff (reset)
      tw_loaded_ff |=> tw_loaded_ff)
      else $error("twiddle loaded flag dropped");

   // multiply-accumulate responses carry zero imaginary parts, both flags set
   a_gemm_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !bypass_ff && !fft_mode_ff) |->
         (rsp_mac_out_im == '0 && rsp_x_out_im == '0 &&
          rsp_mac_out_valid && rsp_x_out_valid))
      else $error("malformed multiply-accumulate response");

endmodule

`default_nettype wire
